[src/lps_pkg.sv]
// shared types, constants and helpers for the line pixel stepper
`timescale 1ns / 1ps

package lps_pkg;

    localparam int COORD_BITS = 12;
    localparam int IDX_BITS   = COORD_BITS + 1;
    localparam int COLOR_BITS = 32;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_NEXT = 1'b1
    } op_t;

    // one command transfer
    typedef struct packed {
        op_t    op;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t color_in;
    } cmd_t;

    // one pixel transfer
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t color_out;
        logic   pixel_valid;
        logic   last;
    } pix_t;

    typedef struct packed {
        logic y_major;
        logic y_neg;
        logic x_neg;
    } dir_t;

    // line walker state
    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t major_len;
        coord_t minor_len;
        idx_t   step_index;
        coord_t minor_offset;
        idx_t   remainder_acc;
        dir_t   dir_flags;
        color_t line_color;
        logic   active;
    } state_t;

    // move from base by delta, wrapping at the coordinate width
    function automatic coord_t along(input coord_t base, input coord_t delta, input logic neg);
        coord_t res;
        res = neg ? (base - delta) : (base + delta);
        return res;
    endfunction

endpackage

[src/lps_step.sv]
// next-state and pixel logic for one command of the line pixel stepper
`timescale 1ns / 1ps

module lps_step (
    input  lps_pkg::cmd_t   cmd,
    input  lps_pkg::state_t state,
    output lps_pkg::state_t state_next,
    output lps_pkg::pix_t   pix_next
);

    lps_pkg::coord_t adx;
    lps_pkg::coord_t ady;
    logic            x_neg;
    logic            y_neg;
    logic            y_major;
    lps_pkg::coord_t major_l;
    lps_pkg::idx_t   step_n;
    lps_pkg::idx_t   rem_sum;
    lps_pkg::idx_t   major_ext;
    logic            wrap;
    lps_pkg::idx_t   rem_n;
    lps_pkg::coord_t off_n;
    logic            min_neg;
    lps_pkg::coord_t moff;
    lps_pkg::coord_t step_c;

    // load path: deltas and axis choice
    always_comb
    begin
        x_neg   = cmd.end_x < cmd.start_x;
        y_neg   = cmd.end_y < cmd.start_y;
        adx     = x_neg ? (cmd.start_x - cmd.end_x) : (cmd.end_x - cmd.start_x);
        ady     = y_neg ? (cmd.start_y - cmd.end_y) : (cmd.end_y - cmd.start_y);
        y_major = (adx == '0) || (ady > adx);
        major_l = y_major ? ady : adx;
    end

    // step path: exact remainder accumulator
    always_comb
    begin
        major_ext = {1'b0, state.major_len};
        step_n    = state.step_index + lps_pkg::idx_t'(1);
        rem_sum   = state.remainder_acc + {1'b0, state.minor_len};
        wrap      = rem_sum >= major_ext;
        rem_n     = wrap ? (rem_sum - major_ext) : rem_sum;
        off_n     = wrap ? (state.minor_offset + lps_pkg::coord_t'(1)) : state.minor_offset;
        min_neg   = state.dir_flags.y_major ? state.dir_flags.x_neg : state.dir_flags.y_neg;
        // negative minor direction rounds away from the origin
        moff      = off_n + lps_pkg::coord_t'(min_neg && (rem_n != '0));
        step_c    = step_n[lps_pkg::COORD_BITS-1:0];
    end

    always_comb
    begin
        state_next = state;
        pix_next   = '0;
        unique case (cmd.op)
            lps_pkg::OP_LOAD:
            begin
                state_next.origin_x      = cmd.start_x;
                state_next.origin_y      = cmd.start_y;
                state_next.major_len     = major_l;
                state_next.minor_len     = y_major ? adx : ady;
                state_next.step_index    = '0;
                state_next.minor_offset  = '0;
                state_next.remainder_acc = '0;
                state_next.dir_flags     = '{y_major: y_major, y_neg: y_neg, x_neg: x_neg};
                state_next.line_color    = cmd.color_in;
                state_next.active        = major_l != '0;
                pix_next.pixel_x         = cmd.start_x;
                pix_next.pixel_y         = cmd.start_y;
                pix_next.color_out       = cmd.color_in;
                pix_next.pixel_valid     = 1'b1;
                pix_next.last            = major_l == '0;
            end
            lps_pkg::OP_NEXT:
            begin
                if (state.active)
                begin
                    state_next.step_index    = step_n;
                    state_next.remainder_acc = rem_n;
                    state_next.minor_offset  = off_n;
                    state_next.active        = !(step_n >= major_ext);
                    if (state.dir_flags.y_major)
                    begin
                        pix_next.pixel_x = lps_pkg::along(state.origin_x, moff,
                                                          state.dir_flags.x_neg);
                        pix_next.pixel_y = lps_pkg::along(state.origin_y, step_c,
                                                          state.dir_flags.y_neg);
                    end
                    else
                    begin
                        pix_next.pixel_x = lps_pkg::along(state.origin_x, step_c,
                                                          state.dir_flags.x_neg);
                        pix_next.pixel_y = lps_pkg::along(state.origin_y, moff,
                                                          state.dir_flags.y_neg);
                    end
                    pix_next.color_out   = state.line_color;
                    pix_next.pixel_valid = 1'b1;
                    pix_next.last        = step_n == major_ext;
                end
            end
            default:
            begin
                state_next = state;
                pix_next   = '0;
            end
        endcase
    end

endmodule

[src/line_pixel_stepper.sv]
// line pixel stepper top level: command register, line state and pixel register
`timescale 1ns / 1ps

// usage
// - cmd channel (cmd_valid, cmd_stall, cmd): a transfer with op OP_LOAD latches both
//   endpoints and the color and yields the first pixel; op OP_NEXT yields the next pixel
// - pix channel (pix_valid, pix_stall, pix): exactly one transfer per command; last marks
//   the end pixel, pixel_valid is low (all other fields zero) for a pull with no line
// - path: a command lands in the command register, then its pixel is computed in one
//   pass of add, compare and subtract on the remainder and lands in the pixel register,
//   from which it transfers; a receiver stall can hold the command in the command register
// - throughput: one command per cycle while the receiver does not stall, bounded by the
//   remainder update that each pixel makes on the line state
// - reset: no line active, both registers empty, a pull then returns an empty pixel
// - when the receiver stalls, the pixel register holds; the command register still takes
//   one more command, and cmd_stall rises only while both registers are full
// - a load while a line is running drops the old line
module line_pixel_stepper (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  lps_pkg::cmd_t  cmd,
    output logic           pix_valid,
    input  logic           pix_stall,
    output lps_pkg::pix_t  pix
);

    // command register
    lps_pkg::cmd_t   cmd_reg;
    logic            cmd_full_reg;
    logic            cmd_full_next;

    // line state
    lps_pkg::state_t state_reg;
    lps_pkg::state_t state_next;

    // pixel register
    lps_pkg::pix_t   pix_reg;
    lps_pkg::pix_t   pix_next;
    logic            pix_full_reg;
    logic            pix_full_next;

    logic            cmd_take;
    logic            advance;

    // a command moves on when the pixel register is empty or draining this cycle
    assign advance   = cmd_full_reg && (!pix_full_reg || !pix_stall);
    assign cmd_stall = cmd_full_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    lps_step u_step (
        .cmd        (cmd_reg),
        .state      (state_reg),
        .state_next (state_next),
        .pix_next   (pix_next)
    );

    always_comb
    begin
        cmd_full_next = cmd_full_reg;
        if (cmd_take)
        begin
            cmd_full_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_full_next = 1'b0;
        end

        pix_full_next = pix_full_reg;
        if (advance)
        begin
            pix_full_next = 1'b1;
        end
        else if (!pix_stall)
        begin
            pix_full_next = 1'b0;
        end
    end

    // control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg <= 1'b0;
            pix_full_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            cmd_full_reg <= cmd_full_next;
            pix_full_reg <= pix_full_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_valid = pix_full_reg;
    assign pix       = pix_reg;

endmodule

[src/lps_checker.sv]
// port-level checks for the line pixel stepper and their bind
`timescale 1ns / 1ps

module lps_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input lps_pkg::cmd_t cmd,
    input logic          pix_valid,
    input logic          pix_stall,
    input lps_pkg::pix_t pix
);

    // a stalled pixel transfer holds
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix))
        else $error("pixel changed while stalled");

    // commands back up only behind a stalled, full pixel output
    a_cmd_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> pix_valid && pix_stall)
        else $error("command stall without pixel stall");

    // an end-of-line mark only comes with a real pixel
    a_last_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix.last |-> pix.pixel_valid)
        else $error("last set on an empty pixel");

    // an empty pull returns all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix.pixel_valid |->
            pix.pixel_x == '0 && pix.pixel_y == '0 && pix.color_out == '0)
        else $error("empty pixel carries data");

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
);
